### rtl/core/pidsep_pkg.sv
// Shared types, widths and register codes for the PID controller with integral separation.
package pidsep_pkg;

    localparam int unsigned SampleW   = 16;
    localparam int unsigned GainW     = 16;
    localparam int unsigned StartW    = 17;
    localparam int unsigned IntLimW   = 23;
    localparam int unsigned OutLimW   = 15;
    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 23;

    localparam int unsigned DefSmallErrorBand  = 300;
    localparam int unsigned DefGainFractionBits = 8;

    localparam logic [CfgIndexW-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_INT_START = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_INT_LIMIT = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_OUT_LIMIT = 3'd5;

    localparam logic [OutLimW-1:0] OutLimitReset = 15'h7FFF;

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic [CfgIndexW-1:0]      t_cfg_index;
    typedef logic [CfgDataW-1:0]       t_cfg_data;

endpackage

### rtl/core/pidsep_in_if.sv
// Request channel carrying one setpoint and one measurement.
interface pidsep_in_if;
    logic                 valid;
    logic                 ready;
    pidsep_pkg::t_sample  target_value;
    pidsep_pkg::t_sample  measured_value;

    modport source (output valid, output target_value, output measured_value, input ready);
    modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

### rtl/core/pidsep_out_if.sv
// Result channel carrying one saturated drive value.
interface pidsep_out_if;
    logic                 valid;
    logic                 ready;
    pidsep_pkg::t_sample  drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

### rtl/core/pid_with_integral_separation.sv
// Positional PID controller with integral separation, clamping and a scheduled P gain.
//
// Requests arrive on i_req (target_value, measured_value) and each produces exactly
// one drive_value on o_rsp; both channels use a valid/ready handshake.
// Gains and limits are written through the plain write port (i_cfg_we, i_cfg_index,
// i_cfg_data); the user must write them only while the controller is idle, which the
// block itself does not enforce. Indexes beyond the register list are ignored.
// One request is processed at a time and i_req.ready is high only when the sequencer
// is idle. A single 33 by 24 bit multiplier and one accumulator are reused for the
// integral, derivative and proportional products.
// When |error| is below the small error band the proportional index is found by a
// reciprocal multiplication on the same multiplier in states S_IX0 to S_IX2.
// A result waits in the output register while o_rsp.ready is low; a new request can be
// taken meanwhile, but its result is held back until the previous one has gone.
// Synchronous reset clears the history, the error sum, the gains and the limits, and
// sets the output limit to full scale.
module pid_with_integral_separation #(
    parameter int unsigned SMALL_ERROR_BAND   = pidsep_pkg::DefSmallErrorBand,
    parameter int unsigned GAIN_FRACTION_BITS = pidsep_pkg::DefGainFractionBits
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  pidsep_pkg::t_cfg_index i_cfg_index,
    input  pidsep_pkg::t_cfg_data  i_cfg_data,
    pidsep_in_if.sink              i_req,
    pidsep_out_if.source           o_rsp
);
    import pidsep_pkg::*;

    localparam int unsigned DivW   = $clog2(10 * SMALL_ERROR_BAND + 1);
    localparam int unsigned ShiftN = GAIN_FRACTION_BITS + 15;
    localparam int unsigned AccW   = 58;
    localparam int unsigned ProdW  = 57;
    localparam int unsigned RecipK     = 15 + 2 * DivW;
    localparam int unsigned RecipShift = 2 * DivW;

    localparam logic [DivW-1:0]   Divisor  = DivW'(10 * SMALL_ERROR_BAND);
    localparam logic [DivW+1:0]   SevenB   = (DivW+2)'(7 * SMALL_ERROR_BAND);
    localparam logic [16:0]       Band     = 17'(SMALL_ERROR_BAND);
    localparam logic [AccW-1:0]   RndBias  = (AccW'(1) << ShiftN) - AccW'(1);
    localparam logic [15:0]       IndexOne = 16'h8000;
    localparam logic [63:0]       RecipM   =
        ((64'd1 << RecipK) + 64'(Divisor) - 64'd1) / 64'(Divisor);
    localparam logic [31:0]       RecipLo  = RecipM[31:0];
    localparam logic [31:0]       RecipHi  = RecipM[63:32];

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_INTG  = 4'd2;
    localparam logic [3:0] S_CLAMP = 4'd3;
    localparam logic [3:0] S_IX0   = 4'd4;
    localparam logic [3:0] S_IX1   = 4'd5;
    localparam logic [3:0] S_IX2   = 4'd6;
    localparam logic [3:0] S_M0    = 4'd7;
    localparam logic [3:0] S_M1    = 4'd8;
    localparam logic [3:0] S_M2    = 4'd9;
    localparam logic [3:0] S_M3    = 4'd10;
    localparam logic [3:0] S_M4    = 4'd11;
    localparam logic [3:0] S_SHIFT = 4'd12;
    localparam logic [3:0] S_SAT   = 4'd13;

    logic [GainW-1:0]          r_gain_p, r_gain_i, r_gain_d;
    logic [StartW-1:0]         r_int_start;
    logic [IntLimW-1:0]        r_int_limit;
    logic [OutLimW-1:0]        r_out_limit;

    logic [3:0]                r_state, n_state;
    logic signed [16:0]        r_err;
    logic signed [16:0]        r_prev;
    logic [16:0]               r_abs;
    logic signed [17:0]        r_deriv;
    logic signed [24:0]        r_sum;
    logic [23:0]               r_load;
    logic [15:0]               r_idx;
    logic signed [ProdW-1:0]   r_prod;
    logic signed [AccW-1:0]    r_acc;
    logic                      r_out_valid;
    t_sample                   r_drive;

    logic [31:0]               w_mul_a;
    logic signed [23:0]        w_mul_b;
    logic signed [ProdW-1:0]   w_prod;
    logic [DivW+1:0]           w_load;
    logic signed [24:0]        w_lim;
    logic signed [AccW-1:0]    w_olim;
    logic                      w_accept;
    logic                      w_out_free;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.drive_value = r_drive;

    assign w_prod  = $signed({1'b0, w_mul_a}) * w_mul_b;
    assign w_load  = SevenB + (DivW+2)'({r_abs, 1'b0}) + (DivW+2)'(r_abs);
    assign w_lim   = $signed({2'b00, r_int_limit});
    assign w_olim  = $signed({(AccW-OutLimW)'(0), r_out_limit});

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_IX0: begin
                w_mul_a = RecipLo;
                w_mul_b = $signed(r_load);
            end
            S_IX1: begin
                w_mul_a = RecipHi;
                w_mul_b = $signed(r_load);
            end
            S_M0: begin
                w_mul_a = 32'(r_gain_i);
                w_mul_b = r_sum[23:0];
            end
            S_M1: begin
                w_mul_a = 32'(r_gain_d);
                w_mul_b = 24'(r_deriv);
            end
            S_M2: begin
                w_mul_a = 32'(r_gain_p);
                w_mul_b = $signed({8'd0, r_idx});
            end
            S_M3: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = 24'(r_err);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_PREP;
            S_PREP:  n_state = S_INTG;
            S_INTG:  n_state = S_CLAMP;
            S_CLAMP: n_state = (r_abs >= Band) ? S_M0 : S_IX0;
            S_IX0:   n_state = S_IX1;
            S_IX1:   n_state = S_IX2;
            S_IX2:   n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_SHIFT;
            S_SHIFT: n_state = S_SAT;
            S_SAT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_int_start <= '0;
            r_int_limit <= '0;
            r_out_limit <= OutLimitReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GAIN_P:    r_gain_p    <= i_cfg_data[GainW-1:0];
                REG_GAIN_I:    r_gain_i    <= i_cfg_data[GainW-1:0];
                REG_GAIN_D:    r_gain_d    <= i_cfg_data[GainW-1:0];
                REG_INT_START: r_int_start <= i_cfg_data[StartW-1:0];
                REG_INT_LIMIT: r_int_limit <= i_cfg_data[IntLimW-1:0];
                REG_OUT_LIMIT: r_out_limit <= i_cfg_data[OutLimW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_SAT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_err <= 17'(i_req.target_value) - 17'(i_req.measured_value);
                    end
                end
                S_PREP: begin
                    r_abs   <= r_err[16] ? 17'(-r_err) : 17'(r_err);
                    r_deriv <= 18'(r_err) - 18'(r_prev);
                    r_prev  <= r_err;
                end
                S_INTG: begin
                    if ({1'b0, r_abs} < {1'b0, r_int_start}) begin
                        r_sum <= r_sum + 25'(r_err);
                    end
                    r_load <= 24'(w_load);
                end
                S_CLAMP: begin
                    if (r_sum > w_lim) begin
                        r_sum <= w_lim;
                    end else if (r_sum < -w_lim) begin
                        r_sum <= -w_lim;
                    end
                    r_idx <= IndexOne;
                end
                S_IX0: begin
                    r_prod <= w_prod;
                end
                S_IX1: begin
                    r_prod <= w_prod;
                    r_acc  <= AccW'(r_prod);
                end
                S_IX2: begin
                    r_idx <= 16'((r_acc + (AccW'(r_prod) <<< 32)) >>> RecipShift);
                end
                S_M0: begin
                    r_prod <= w_prod;
                end
                S_M1: begin
                    r_prod <= w_prod;
                    r_acc  <= AccW'(r_prod);
                end
                S_M2: begin
                    r_prod <= w_prod;
                    r_acc  <= r_acc + AccW'(r_prod);
                end
                S_M3: begin
                    r_prod <= w_prod;
                    r_acc  <= r_acc <<< 15;
                end
                S_M4: begin
                    r_acc <= r_acc + AccW'(r_prod);
                end
                S_SHIFT: begin
                    r_acc <= (r_acc + (r_acc[AccW-1] ? $signed(RndBias)
                                                     : $signed(AccW'(0)))) >>> ShiftN;
                end
                S_SAT: begin
                    if (w_out_free) begin
                        if (r_acc > w_olim) begin
                            r_drive <= $signed({1'b0, r_out_limit});
                        end else if (r_acc < -w_olim) begin
                            r_drive <= -$signed({1'b0, r_out_limit});
                        end else begin
                            r_drive <= r_acc[15:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_PREP))
        else $error("accepted request did not start the sequencer");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M2) |-> (r_idx <= IndexOne))
        else $error("proportional index above one");

    a_index_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_M2) && (r_abs < Band)) |-> (r_idx < IndexOne))
        else $error("proportional index not reduced inside the band");

    a_sum_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0) |-> ((r_sum <= w_lim) && (r_sum >= -w_lim)))
        else $error("error sum outside its limit");

    a_drive_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) || ((r_state == S_IDLE) && $past(r_state) == S_SAT)) |->
        (($signed(r_drive) <= $signed({1'b0, r_out_limit}))
        && ($signed(r_drive) >= -$signed({1'b0, r_out_limit}))))
        else $error("drive value outside the output limit");

endmodule
